[rtl/core/alpha_unpremultiply_pixel_macros.svh]
// Assertion macros for the checker file of the pixel straightening block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ALPHA_UNPREMULTIPLY_PIXEL_MACROS_SVH
`define ALPHA_UNPREMULTIPLY_PIXEL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define AUP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define AUP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/aup_pkg.sv]
// Shared constants and types for the pixel straightening block.
// No dependencies; imported by every module of the block.
package aup_pkg;

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   // one lane per colour channel
   localparam int LANES = 3;

   // restoring division, two quotient bits per pipeline stage
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = PIX_W / BITS_PER_STAGE;
   localparam int PIPE_STAGES    = DIV_STAGES + 1;

   typedef struct packed {
      logic [PIX_W-1:0] alpha_in;
      logic [PIX_W-1:0] chan2_in;
      logic [PIX_W-1:0] chan1_in;
      logic [PIX_W-1:0] chan0_in;
   } aup_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] alpha_out;
      logic [PIX_W-1:0] chan2_out;
      logic [PIX_W-1:0] chan1_out;
      logic [PIX_W-1:0] chan0_out;
   } aup_rsp_type;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
   } aup_pipe_ctl_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic [PIX_W-1:0] chan;
      logic [PIX_W-1:0] alpha;
   } aup_lane_out_type;

endpackage

[rtl/core/aup_lane.sv]
// One colour lane: channel*255/alpha by pipelined restoring division, with saturation
// and the alpha 0 / 255 pass-through. Depends on aup_pkg.
module aup_lane (
   input  logic                          clock,
   input  aup_pkg::aup_pipe_ctl_type     ctl,
   input  logic [aup_pkg::PIX_W-1:0]     chan_in,
   input  logic [aup_pkg::PIX_W-1:0]     alpha_in,
   output aup_pkg::aup_lane_out_type     lane_out
);
   import aup_pkg::*;

   localparam int PROD_W = 2 * PIX_W;
   localparam int LAST   = PIPE_STAGES - 1;

   // one division step: returns {quotient bit, new remainder}
   function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
                                                input logic din,
                                                input logic [PIX_W-1:0] dsr);
      logic [PIX_W:0] trial;
      logic [PIX_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, dsr};
      if (trial >= {1'b0, dsr}) begin
         return {1'b1, diff[PIX_W-1:0]};
      end else begin
         return {1'b0, trial[PIX_W-1:0]};
      end
   endfunction

   logic [PIX_W-1:0] chan_ff   [PIPE_STAGES];
   logic [PIX_W-1:0] alpha_ff  [PIPE_STAGES];
   logic [PIX_W-1:0] rem_ff    [PIPE_STAGES];
   logic [PIX_W-1:0] dvd_ff    [PIPE_STAGES];
   logic [PIX_W-1:0] quo_ff    [PIPE_STAGES];
   logic             bypass_ff [PIPE_STAGES];
   logic             sat_ff    [PIPE_STAGES];

   logic [PIX_W-1:0] chan_in_s [PIPE_STAGES];
   logic [PIX_W-1:0] alpha_in_s[PIPE_STAGES];
   logic [PIX_W-1:0] rem_in    [PIPE_STAGES];
   logic [PIX_W-1:0] dvd_in    [PIPE_STAGES];
   logic [PIX_W-1:0] quo_in    [PIPE_STAGES];
   logic             bypass_in [PIPE_STAGES];
   logic             sat_in    [PIPE_STAGES];

   logic [PROD_W-1:0] prod;

   // channel*255 as a shift and subtract
   assign prod = {chan_in, PIX_W'(0)} - {PIX_W'(0), chan_in};

   // next values for every stage
   always_comb begin
      logic [PIX_W-1:0] rem_w;
      logic [PIX_W-1:0] dvd_w;
      logic [PIX_W-1:0] quo_w;
      logic [PIX_W:0]   step;

      // entry stage: split the product, flag saturation and pass-through
      chan_in_s[0]  = chan_in;
      alpha_in_s[0] = alpha_in;
      bypass_in[0]  = (alpha_in == '0) || (alpha_in == PIX_MAX);
      sat_in[0]     = prod >= {alpha_in, PIX_W'(0)};
      rem_in[0]     = prod[PROD_W-1:PIX_W];
      dvd_in[0]     = prod[PIX_W-1:0];
      quo_in[0]     = '0;

      // division stages
      for (int s = 1; s < PIPE_STAGES; s++) begin
         rem_w = rem_ff[s-1];
         dvd_w = dvd_ff[s-1];
         quo_w = quo_ff[s-1];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            step  = div_step(rem_w, dvd_w[PIX_W-1], alpha_ff[s-1]);
            rem_w = step[PIX_W-1:0];
            quo_w = {quo_w[PIX_W-2:0], step[PIX_W]};
            dvd_w = {dvd_w[PIX_W-2:0], 1'b0};
         end
         chan_in_s[s]  = chan_ff[s-1];
         alpha_in_s[s] = alpha_ff[s-1];
         bypass_in[s]  = bypass_ff[s-1];
         sat_in[s]     = sat_ff[s-1];
         rem_in[s]     = rem_w;
         dvd_in[s]     = dvd_w;
         quo_in[s]     = quo_w;
      end
   end

   // stage registers, payload only
   always_ff @(posedge clock) begin
      for (int s = 0; s < PIPE_STAGES; s++) begin
         if (ctl.load[s]) begin
            chan_ff[s]   <= chan_in_s[s];
            alpha_ff[s]  <= alpha_in_s[s];
            bypass_ff[s] <= bypass_in[s];
            sat_ff[s]    <= sat_in[s];
            rem_ff[s]    <= rem_in[s];
            dvd_ff[s]    <= dvd_in[s];
            quo_ff[s]    <= quo_in[s];
         end
      end
   end

   // final pick: pass-through, saturate, or quotient
   always_comb begin
      if (bypass_ff[LAST]) begin
         lane_out.chan = chan_ff[LAST];
      end else if (sat_ff[LAST]) begin
         lane_out.chan = PIX_MAX;
      end else begin
         lane_out.chan = quo_ff[LAST];
      end
      lane_out.alpha = alpha_ff[LAST];
   end

endmodule

[rtl/core/aup_merge.sv]
// Merge stage: gathers the lane results into one pixel and holds it in the output register.
// Depends on aup_pkg.
module aup_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  aup_pkg::aup_lane_out_type  lane_res [aup_pkg::LANES],
   input  logic                       in_valid,
   output logic                       in_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output aup_pkg::aup_rsp_type       rsp_data
);
   import aup_pkg::*;

   logic        rsp_valid_ff;
   aup_rsp_type rsp_data_ff;
   aup_rsp_type rsp_data_in;

   // output register is free when empty or being drained this cycle
   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_data_in.chan0_out = lane_res[0].chan;
      rsp_data_in.chan1_out = lane_res[1].chan;
      rsp_data_in.chan2_out = lane_res[2].chan;
      rsp_data_in.alpha_out = lane_res[0].alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/alpha_unpremultiply_pixel.sv]
// Pixel straightening: premultiplied RGBA8888 in, straight alpha out.
// Uses aup_pkg, aup_lane (three colour lanes) and aup_merge (output register).
//
// Input: req_valid / req_ready / req_data, one pixel per transfer.
// Output: rsp_valid / rsp_ready / rsp_data, exactly one pixel per input, in order.
// Each colour channel becomes floor(chan*255/alpha), saturated at 255; alpha 0
// and 255 leave the channels as they are; alpha passes straight through.
// Path from input to result: entry stage, four division stages of two quotient bits
// each, then the output register.
// Throughput: one pixel per cycle while rsp_ready stays high; the three lanes work in
// parallel and each division stage takes a fresh pixel every cycle unless stalled.
// When rsp_ready is low, stages fill up one by one behind the held result;
// req_ready drops only once every stage holds a pixel.
// Reset clears all stage valid flags and the output valid; nothing else is kept.
module alpha_unpremultiply_pixel (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  aup_pkg::aup_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output aup_pkg::aup_rsp_type  rsp_data
);
   import aup_pkg::*;

   logic [PIPE_STAGES-1:0] pipe_valid_ff;
   logic [PIPE_STAGES-1:0] pipe_valid_in;
   logic [PIPE_STAGES:0]   take;
   logic                   merge_ready;
   aup_pipe_ctl_type       ctl;
   logic [PIX_W-1:0]       lane_chan [LANES];
   aup_lane_out_type       lane_res  [LANES];

   // a stage can load when empty or when the stage after it can load
   always_comb begin
      take[PIPE_STAGES] = merge_ready;
      for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
         take[i] = !pipe_valid_ff[i] || take[i+1];
      end
      ctl.load = take[PIPE_STAGES-1:0];
   end

   assign req_ready     = take[0];
   assign pipe_valid_in = {pipe_valid_ff[PIPE_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            if (ctl.load[i]) begin
               pipe_valid_ff[i] <= pipe_valid_in[i];
            end
         end
      end
   end

   // colour lanes
   assign lane_chan[0] = req_data.chan0_in;
   assign lane_chan[1] = req_data.chan1_in;
   assign lane_chan[2] = req_data.chan2_in;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      aup_lane u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .chan_in  (lane_chan[g]),
         .alpha_in (req_data.alpha_in),
         .lane_out (lane_res[g])
      );
   end

   aup_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_res  (lane_res),
      .in_valid  (pipe_valid_ff[PIPE_STAGES-1]),
      .in_ready  (merge_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/aup_checker.sv]
// Port-level checks for the pixel straightening block, bound to its top level.
// Depends on aup_pkg and alpha_unpremultiply_pixel_macros.svh.
`include "alpha_unpremultiply_pixel_macros.svh"

module aup_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input aup_pkg::aup_req_type  req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input aup_pkg::aup_rsp_type  rsp_data
);
   import aup_pkg::*;

   // a held result keeps its payload until the transfer
   `AUP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // no result in the cycle after a reset edge
   `AUP_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // with the output register empty, the pipeline can always take a pixel
   `AUP_ASSERT_NOW(a_req_open, clock, reset, !rsp_valid, req_ready, "input blocked with empty output")

endmodule

bind alpha_unpremultiply_pixel aup_checker u_aup_checker (.*);
